// ===== src/ndtv_pkg.sv =====
// Shared types, widths, register codes and neighbor table for the voxel count core.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
`timescale 1ns / 1ps
`default_nettype none

package ndtv_pkg;

    localparam int GRID_CELLS_DEF = 4096;
    localparam int Q_DEPTH        = 2;

    localparam int INV_W      = 16;
    localparam int MIN_W      = 16;
    localparam int SIZE_W     = 13;
    localparam int CNT_W      = 16;
    localparam int COORD_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 12;
    localparam int NCNT_W     = 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W = COORD_W + INV_W + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int D_W    = 15;
    localparam int SXY_W  = 2 * SIZE_W;
    localparam int PY_W   = D_W + SIZE_W + 1;
    localparam int PZ_W   = D_W + SXY_W + 1;
    localparam int BASE_W = PZ_W + 1;

    localparam logic signed [DIFF_W-1:0] DIFF_LO = -25'sd2;
    localparam logic signed [DIFF_W-1:0] DIFF_HI = 25'sd8192;

    localparam logic KIND_ACC = 1'b0;
    localparam logic KIND_QRY = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_INV_RES  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_X    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Z    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PTS  = 3'd7;

    localparam logic [INV_W-1:0]         INV_RES_RST = 16'd512;
    localparam logic signed [MIN_W-1:0]  BOX_MIN_RST = -16'sd8;
    localparam logic [SIZE_W-1:0]        SIZE_RST    = 13'd16;
    localparam logic [CNT_W-1:0]         MIN_PTS_RST = 16'd6;
    localparam logic [CNT_W-1:0]         CNT_MAX     = '1;

    localparam logic [1:0] AX_NONE = 2'd0;
    localparam logic [1:0] AX_X    = 2'd1;
    localparam logic [1:0] AX_Y    = 2'd2;
    localparam logic [1:0] AX_Z    = 2'd3;

    localparam logic [2:0] NBR_LAST = 3'd6;

    typedef struct packed {
        logic [INV_W-1:0]        inv_res;
        logic signed [MIN_W-1:0] min_x;
        logic signed [MIN_W-1:0] min_y;
        logic signed [MIN_W-1:0] min_z;
        logic [SIZE_W-1:0]       size_x;
        logic [SIZE_W-1:0]       size_y;
        logic [SIZE_W-1:0]       size_z;
        logic [CNT_W-1:0]        min_points;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
    } q_item_t;

    typedef struct packed {
        logic q_ready;
        logic clearing;
    } back_stat_t;

    // center, +x, -x, +y, -y, +z, -z
    function automatic logic [1:0] nbr_axis(input logic [2:0] k);
        logic [1:0] a;
        case (k)
            3'd1, 3'd2: a = AX_X;
            3'd3, 3'd4: a = AX_Y;
            3'd5, 3'd6: a = AX_Z;
            default:    a = AX_NONE;
        endcase
        return a;
    endfunction

    function automatic logic nbr_neg(input logic [2:0] k);
        logic n;
        case (k)
            3'd2, 3'd4, 3'd6: n = 1'b1;
            default:          n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/ndtv_front.sv =====
// Front end: accepts requests, scales points to voxel coordinates, queues them.
// Depends on ndtv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndtv_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire ndtv_pkg::cfg_t                       cfg,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_kind,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]  s_x,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]  s_y,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]  s_z,
    input  wire ndtv_pkg::back_stat_t                 stat,
    output logic                                      q_valid,
    output ndtv_pkg::q_item_t                         q_item
);

    localparam int QPW = (ndtv_pkg::Q_DEPTH > 1) ? $clog2(ndtv_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(ndtv_pkg::Q_DEPTH + 1);
    localparam int VHI = ndtv_pkg::COORD_W + ndtv_pkg::FRAC_W - 1;

    ndtv_pkg::q_item_t fifo_reg [ndtv_pkg::Q_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    logic signed [ndtv_pkg::PROD_W-1:0] px, py, pz;
    logic signed [ndtv_pkg::INV_W:0]    inv_s;
    ndtv_pkg::q_item_t                  item_in;
    logic push, pop;

    assign inv_s = $signed({1'b0, cfg.inv_res});
    assign px    = s_x * inv_s;
    assign py    = s_y * inv_s;
    assign pz    = s_z * inv_s;

    always_comb begin
        item_in.kind = s_kind;
        item_in.vx   = px[VHI:ndtv_pkg::FRAC_W];
        item_in.vy   = py[VHI:ndtv_pkg::FRAC_W];
        item_in.vz   = pz[VHI:ndtv_pkg::FRAC_W];
    end

    assign s_ready = (count_reg != QCW'(ndtv_pkg::Q_DEPTH)) && !stat.clearing;
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && stat.q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(ndtv_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(ndtv_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ndtv_back.sv =====
// Back end: count store with clearing pass, neighbor probe sequencer, result register.
// Depends on ndtv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ndtv_back #(
    parameter int GRID_CELLS = ndtv_pkg::GRID_CELLS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ndtv_pkg::cfg_t                     cfg,
    input  wire logic                               q_valid,
    input  wire ndtv_pkg::q_item_t                  q_item,
    output ndtv_pkg::back_stat_t                    stat,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ndtv_pkg::IDX_W-1:0]              m_cell_index,
    output logic                                    m_found,
    output logic                                    m_status,
    output logic [ndtv_pkg::NCNT_W-1:0]             m_neighbor_count,
    output logic                                    m_last
);

    localparam int AW     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int D_W    = ndtv_pkg::D_W;
    localparam int BASE_W = ndtv_pkg::BASE_W;
    localparam int IDX_W  = ndtv_pkg::IDX_W;
    localparam int NCNT_W = ndtv_pkg::NCNT_W;
    localparam int CNT_W  = ndtv_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_BASE  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    function automatic logic signed [D_W-1:0] clamp_d(
        input logic signed [ndtv_pkg::COORD_W-1:0] v,
        input logic signed [ndtv_pkg::MIN_W-1:0]   m
    );
        logic signed [ndtv_pkg::DIFF_W-1:0] d;
        logic signed [D_W-1:0]              r;
        d = {v[ndtv_pkg::COORD_W-1], v} - {{9{m[ndtv_pkg::MIN_W-1]}}, m};
        if (d < ndtv_pkg::DIFF_LO) begin
            r = ndtv_pkg::DIFF_LO[D_W-1:0];
        end else if (d > ndtv_pkg::DIFF_HI) begin
            r = ndtv_pkg::DIFF_HI[D_W-1:0];
        end else begin
            r = d[D_W-1:0];
        end
        return r;
    endfunction

    function automatic logic axis_in(
        input logic signed [D_W-1:0]         d,
        input logic signed [1:0]             o,
        input logic [ndtv_pkg::SIZE_W-1:0]   sz
    );
        logic signed [D_W:0] dn;
        dn = {d[D_W-1], d} + {{(D_W-1){o[1]}}, o};
        return !dn[D_W] && (dn[D_W-1:0] < {2'b00, sz});
    endfunction

    logic [CNT_W-1:0] mem [GRID_CELLS];

    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        k_reg, k_next;
    logic [NCNT_W-1:0]                 n_reg, n_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic                              clr_active_reg, clr_active_next;
    logic [AW-1:0]                     clr_addr_reg, clr_addr_next;
    logic                              m_valid_reg, m_valid_next;

    logic                              kind_reg;
    logic signed [D_W-1:0]             dx_reg, dy_reg, dz_reg;
    logic signed [ndtv_pkg::PY_W-1:0]  py_reg;
    logic signed [ndtv_pkg::PZ_W-1:0]  pz_reg;
    logic signed [BASE_W-1:0]          base_reg;
    logic                              in_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [AW-1:0]                     addr_reg;
    logic [CNT_W-1:0]                  rd_data_reg;
    logic [IDX_W-1:0]                  pend_idx_reg;
    logic [NCNT_W-1:0]                 pend_cnt_reg;
    logic [ndtv_pkg::SXY_W-1:0]        sxsy_reg;
    logic [CNT_W-1:0]                  thr_reg;
    logic [IDX_W-1:0]                  m_cell_index_reg;
    logic                              m_found_reg;
    logic                              m_status_reg;
    logic [NCNT_W-1:0]                 m_neighbor_count_reg;
    logic                              m_last_reg;

    logic                              pop, out_free, hit, stall;
    logic [1:0]                        axis;
    logic                              neg;
    logic signed [1:0]                 o_step, ox, oy, oz;
    logic signed [BASE_W-1:0]          mag, off, cand;
    logic                              cand_in;
    logic signed [ndtv_pkg::SIZE_W:0]  sx_s;
    logic signed [ndtv_pkg::SXY_W:0]   sxy_s;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [CNT_W-1:0]                  mem_wdata;

    logic                              out_load;
    logic [IDX_W-1:0]                  out_idx;
    logic                              out_found, out_status, out_last;
    logic [NCNT_W-1:0]                 out_cnt;

    assign stat.q_ready  = (state_reg == ST_IDLE) && !clr_active_reg;
    assign stat.clearing = clr_active_reg;
    assign pop           = q_valid && stat.q_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign hit           = in_reg && (rd_data_reg >= thr_reg);
    assign stall         = hit && pend_valid_reg && !out_free;

    assign sx_s  = $signed({1'b0, cfg.size_x});
    assign sxy_s = $signed({1'b0, sxsy_reg});

    always_comb begin
        axis   = ndtv_pkg::nbr_axis(k_reg);
        neg    = ndtv_pkg::nbr_neg(k_reg);
        o_step = neg ? -2'sd1 : 2'sd1;
        ox     = (axis == ndtv_pkg::AX_X) ? o_step : 2'sd0;
        oy     = (axis == ndtv_pkg::AX_Y) ? o_step : 2'sd0;
        oz     = (axis == ndtv_pkg::AX_Z) ? o_step : 2'sd0;
        case (axis)
            ndtv_pkg::AX_X: mag = BASE_W'(1);
            ndtv_pkg::AX_Y: mag = $signed({{(BASE_W - ndtv_pkg::SIZE_W){1'b0}}, cfg.size_x});
            ndtv_pkg::AX_Z: mag = $signed({{(BASE_W - ndtv_pkg::SXY_W){1'b0}}, sxsy_reg});
            default:        mag = '0;
        endcase
        off     = neg ? -mag : mag;
        cand    = base_reg + off;
        cand_in = axis_in(dx_reg, ox, cfg.size_x) && axis_in(dy_reg, oy, cfg.size_y)
                  && axis_in(dz_reg, oz, cfg.size_z)
                  && (cand < $signed(BASE_W'(GRID_CELLS)));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = (rd_data_reg == ndtv_pkg::CNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_CHECK && kind_reg == ndtv_pkg::KIND_ACC
                     && in_reg && out_free) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        out_load        = 1'b0;
        out_idx         = '0;
        out_found       = 1'b0;
        out_status      = 1'b0;
        out_cnt         = '0;
        out_last        = 1'b0;

        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(GRID_CELLS - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_BASE;
            end
            ST_BASE: begin
                k_next          = '0;
                n_next          = '0;
                pend_valid_next = 1'b0;
                state_next      = ST_PROBE;
            end
            ST_PROBE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (kind_reg == ndtv_pkg::KIND_ACC) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_idx    = in_reg ? idx_reg : '0;
                        out_found  = in_reg;
                        out_status = !in_reg;
                        out_last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!stall) begin
                    if (hit && pend_valid_reg) begin
                        out_load  = 1'b1;
                        out_idx   = pend_idx_reg;
                        out_found = 1'b1;
                        out_cnt   = pend_cnt_reg;
                    end
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + 3'd1;
                    end
                    if (k_reg == ndtv_pkg::NBR_LAST) begin
                        state_next = ST_FLUSH;
                    end else begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_idx    = pend_valid_reg ? pend_idx_reg : '0;
                    out_found  = pend_valid_reg;
                    out_cnt    = pend_valid_reg ? pend_cnt_reg : '0;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_PROBE) begin
            rd_data_reg <= mem[cand[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        sxsy_reg <= cfg.size_x * cfg.size_y;
        thr_reg  <= (cfg.min_points == '0) ? CNT_W'(1) : cfg.min_points;
        if (pop) begin
            kind_reg <= q_item.kind;
            dx_reg   <= clamp_d(q_item.vx, cfg.min_x);
            dy_reg   <= clamp_d(q_item.vy, cfg.min_y);
            dz_reg   <= clamp_d(q_item.vz, cfg.min_z);
        end
        if (state_reg == ST_MUL) begin
            py_reg <= dy_reg * sx_s;
            pz_reg <= dz_reg * sxy_s;
        end
        if (state_reg == ST_BASE) begin
            base_reg <= BASE_W'(dx_reg) + BASE_W'(py_reg) + BASE_W'(pz_reg);
        end
        if (state_reg == ST_PROBE) begin
            in_reg   <= cand_in;
            idx_reg  <= cand[IDX_W-1:0];
            addr_reg <= cand[AW-1:0];
        end
        if (state_reg == ST_CHECK && kind_reg == ndtv_pkg::KIND_QRY && !stall && hit) begin
            pend_idx_reg <= idx_reg;
            pend_cnt_reg <= n_reg + 3'd1;
        end
        if (out_load) begin
            m_cell_index_reg     <= out_idx;
            m_found_reg          <= out_found;
            m_status_reg         <= out_status;
            m_neighbor_count_reg <= out_cnt;
            m_last_reg           <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_cell_index     = m_cell_index_reg;
    assign m_found          = m_found_reg;
    assign m_status         = m_status_reg;
    assign m_neighbor_count = m_neighbor_count_reg;
    assign m_last           = m_last_reg;

    a_no_result_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !m_valid_reg)
        else $error("result presented during count store clear");

    a_flush_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && pend_valid_reg) |-> (pend_cnt_reg == n_reg))
        else $error("held neighbor count disagrees with hit count");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (clr_active_reg
                    || (state_reg == ST_CHECK && kind_reg == ndtv_pkg::KIND_ACC)))
        else $error("count store written outside clear or accumulate");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after final result");

    a_acc_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && kind_reg == ndtv_pkg::KIND_ACC) |-> out_last)
        else $error("accumulate request gave a non-final result");

endmodule

`default_nettype wire

// ===== src/ndt_voxel_count_and_neighbor_lookup_core.sv =====
// Requests wait in a two-entry queue in the front end; the back-end sequencer takes the
// next request only after the previous one has given its final result. The single count
// store read port probes a query's seven-voxel neighborhood one voxel at a time.
// Reset: synchronous active-low; afterwards a clearing pass over every cell zeroes the
// count store and holds s_ready low. Configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module ndt_voxel_count_and_neighbor_lookup_core #(
    parameter int GRID_CELLS = ndtv_pkg::GRID_CELLS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [ndtv_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [ndtv_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_kind,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]   s_x,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]   s_y,
    input  wire logic signed [ndtv_pkg::COORD_W-1:0]   s_z,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [ndtv_pkg::IDX_W-1:0]                 m_cell_index,
    output logic                                       m_found,
    output logic                                       m_status,
    output logic [ndtv_pkg::NCNT_W-1:0]                m_neighbor_count,
    output logic                                       m_last
);

    ndtv_pkg::cfg_t       cfg_reg;
    ndtv_pkg::back_stat_t stat;
    ndtv_pkg::q_item_t    q_item;
    logic                 q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inv_res    <= ndtv_pkg::INV_RES_RST;
            cfg_reg.min_x      <= ndtv_pkg::BOX_MIN_RST;
            cfg_reg.min_y      <= ndtv_pkg::BOX_MIN_RST;
            cfg_reg.min_z      <= ndtv_pkg::BOX_MIN_RST;
            cfg_reg.size_x     <= ndtv_pkg::SIZE_RST;
            cfg_reg.size_y     <= ndtv_pkg::SIZE_RST;
            cfg_reg.size_z     <= ndtv_pkg::SIZE_RST;
            cfg_reg.min_points <= ndtv_pkg::MIN_PTS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ndtv_pkg::REG_INV_RES: cfg_reg.inv_res    <= cfg_data;
                ndtv_pkg::REG_MIN_X:   cfg_reg.min_x      <= cfg_data;
                ndtv_pkg::REG_MIN_Y:   cfg_reg.min_y      <= cfg_data;
                ndtv_pkg::REG_MIN_Z:   cfg_reg.min_z      <= cfg_data;
                ndtv_pkg::REG_SIZE_X:  cfg_reg.size_x     <= cfg_data[ndtv_pkg::SIZE_W-1:0];
                ndtv_pkg::REG_SIZE_Y:  cfg_reg.size_y     <= cfg_data[ndtv_pkg::SIZE_W-1:0];
                ndtv_pkg::REG_SIZE_Z:  cfg_reg.size_z     <= cfg_data[ndtv_pkg::SIZE_W-1:0];
                ndtv_pkg::REG_MIN_PTS: cfg_reg.min_points <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ndtv_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_x     (s_x),
        .s_y     (s_y),
        .s_z     (s_z),
        .stat    (stat),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    ndtv_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_index     (m_cell_index),
        .m_found          (m_found),
        .m_status         (m_status),
        .m_neighbor_count (m_neighbor_count),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// ===== test/ndtv_count_checker.sv =====
// Scoreboard for the voxel count core: follows the config port, predicts the result
// stream of every request and compares what leaves the result channel. Needs ndtv_pkg.
`timescale 1ns / 1ps

module ndtv_count_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ndtv_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [ndtv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_kind,
    input  logic signed [ndtv_pkg::COORD_W-1:0] s_x,
    input  logic signed [ndtv_pkg::COORD_W-1:0] s_y,
    input  logic signed [ndtv_pkg::COORD_W-1:0] s_z,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ndtv_pkg::IDX_W-1:0]          m_cell_index,
    input  logic                                m_found,
    input  logic                                m_status,
    input  logic [ndtv_pkg::NCNT_W-1:0]         m_neighbor_count,
    input  logic                                m_last,
    output int                                  mismatches,
    output int                                  outstanding
);
    import ndtv_pkg::*;

    localparam int MAX_PRINTS = 200;

    typedef struct packed {
        logic [IDX_W-1:0]  cell_idx;
        logic              found;
        logic              status;
        logic [NCNT_W-1:0] hits;
        logic              last;
    } lookup_res_t;

    lookup_res_t      due_results[$];
    logic [CNT_W-1:0] point_count [GRID_CELLS_DEF];
    logic [INV_W-1:0] inv_res;
    logic [CNT_W-1:0] min_pts;
    longint           box_lo [3];
    longint           box_len [3];
    lookup_res_t      got;
    lookup_res_t      want;

    task automatic report(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches = mismatches + 1;
    endtask

    task automatic add_due(input lookup_res_t r);
        due_results.insert(due_results.size(), r);
    endtask

    function automatic lookup_res_t make_res(input longint idx, input logic found,
                                             input logic status, input int hits,
                                             input logic last);
        lookup_res_t r;
        r.cell_idx = idx[IDX_W-1:0];
        r.found    = found;
        r.status   = status;
        r.hits     = hits[NCNT_W-1:0];
        r.last     = last;
        return r;
    endfunction

    // floor(coord * inv_res / 2^16)
    function automatic longint voxel_of(input logic signed [COORD_W-1:0] c);
        longint p;
        p = longint'(c) * longint'(inv_res);
        return p >>> FRAC_W;
    endfunction

    function automatic bit cell_at(input longint vx, input longint vy, input longint vz,
                                   output longint flat);
        longint v [3];
        longint d [3];
        int     a;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        flat = 0;
        for (a = 0; a < 3; a++) begin
            if (v[a] < box_lo[a] || v[a] >= box_lo[a] + box_len[a]) begin
                return 1'b0;
            end
            d[a] = v[a] - box_lo[a];
        end
        flat = d[0] + d[1] * box_len[0] + d[2] * box_len[0] * box_len[1];
        return flat < GRID_CELLS_DEF;
    endfunction

    // visit order: center, +x, -x, +y, -y, +z, -z
    function automatic longint nbr_step(input int k, input int axis);
        case (k)
            1: return (axis == 0) ? 1 : 0;
            2: return (axis == 0) ? -1 : 0;
            3: return (axis == 1) ? 1 : 0;
            4: return (axis == 1) ? -1 : 0;
            5: return (axis == 2) ? 1 : 0;
            6: return (axis == 2) ? -1 : 0;
            default: return 0;
        endcase
    endfunction

    task automatic count_point(input longint vx, input longint vy, input longint vz);
        longint flat;
        if (cell_at(vx, vy, vz, flat)) begin
            if (point_count[flat] != CNT_MAX) begin
                point_count[flat] = point_count[flat] + 1'b1;
            end
            add_due(make_res(flat, 1'b1, 1'b0, 0, 1'b1));
        end else begin
            add_due(make_res(0, 1'b0, 1'b1, 0, 1'b1));
        end
    endtask

    task automatic lookup_neighbors(input longint vx, input longint vy, input longint vz);
        longint      flat;
        longint      thr;
        int          hits;
        int          k;
        hits = 0;
        thr  = (min_pts == 0) ? 1 : longint'(min_pts);
        for (k = 0; k < 7; k++) begin
            if (cell_at(vx + nbr_step(k, 0), vy + nbr_step(k, 1), vz + nbr_step(k, 2), flat)
                && longint'(point_count[flat]) >= thr) begin
                hits = hits + 1;
                add_due(make_res(flat, 1'b1, 1'b0, hits, 1'b0));
            end
        end
        if (hits == 0) begin
            add_due(make_res(0, 1'b0, 1'b0, 0, 1'b1));
        end else begin
            due_results[due_results.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (point_count[i]) begin
                point_count[i] = '0;
            end
            inv_res     = INV_RES_RST;
            min_pts     = MIN_PTS_RST;
            box_lo[0]   = longint'(BOX_MIN_RST);
            box_lo[1]   = longint'(BOX_MIN_RST);
            box_lo[2]   = longint'(BOX_MIN_RST);
            box_len[0]  = longint'(SIZE_RST);
            box_len[1]  = longint'(SIZE_RST);
            box_len[2]  = longint'(SIZE_RST);
            mismatches  = 0;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_INV_RES: inv_res    = cfg_data;
                    REG_MIN_X:   box_lo[0]  = longint'($signed(cfg_data));
                    REG_MIN_Y:   box_lo[1]  = longint'($signed(cfg_data));
                    REG_MIN_Z:   box_lo[2]  = longint'($signed(cfg_data));
                    REG_SIZE_X:  box_len[0] = longint'(cfg_data[SIZE_W-1:0]);
                    REG_SIZE_Y:  box_len[1] = longint'(cfg_data[SIZE_W-1:0]);
                    REG_SIZE_Z:  box_len[2] = longint'(cfg_data[SIZE_W-1:0]);
                    REG_MIN_PTS: min_pts    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_ACC) begin
                    count_point(voxel_of(s_x), voxel_of(s_y), voxel_of(s_z));
                end else begin
                    lookup_neighbors(voxel_of(s_x), voxel_of(s_y), voxel_of(s_z));
                end
            end
            if (m_valid && m_ready) begin
                got.cell_idx = m_cell_index;
                got.found    = m_found;
                got.status   = m_status;
                got.hits     = m_neighbor_count;
                got.last     = m_last;
                if (due_results.size() == 0) begin
                    report($sformatf("unexpected result idx %0d found %0b count %0d last %0b",
                                     got.cell_idx, got.found, got.hits, got.last));
                end else begin
                    want = due_results.pop_front();
                    if (got.cell_idx != want.cell_idx || got.found != want.found
                        || got.status != want.status || got.hits != want.hits
                        || got.last != want.last) begin
                        report($sformatf({"got idx %0d found %0b status %0b count %0d last %0b,",
                                          " want idx %0d found %0b status %0b count %0d last %0b"},
                                         got.cell_idx, got.found, got.status, got.hits, got.last,
                                         want.cell_idx, want.found, want.status, want.hits,
                                         want.last));
                    end
                end
            end
        end
        outstanding = due_results.size();
    end

endmodule

// ===== test/tb_ndt_voxel_count_and_neighbor_lookup_core.sv =====
// Top of the voxel count core bench: clock, reset, config phases, request traffic with
// random idling and back-pressure, watchdog and verdict. Needs ndtv_pkg, the core and
// ndtv_count_checker.
`timescale 1ns / 1ps

module tb_ndt_voxel_count_and_neighbor_lookup_core;
    import ndtv_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam logic signed [COORD_W-1:0] Q_MIN = 24'h800000;
    localparam logic signed [COORD_W-1:0] Q_MAX = 24'h7FFFFF;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      cfg_we   = 1'b0;
    logic [REG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic                      s_kind   = KIND_ACC;
    logic signed [COORD_W-1:0] s_x      = '0;
    logic signed [COORD_W-1:0] s_y      = '0;
    logic signed [COORD_W-1:0] s_z      = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic [IDX_W-1:0]          m_cell_index;
    logic                      m_found;
    logic                      m_status;
    logic [NCNT_W-1:0]         m_neighbor_count;
    logic                      m_last;

    int       mismatches;
    int       outstanding;
    int       stall_cycles = 0;
    int       hold_left    = 0;
    int       gap_left     = 0;
    int       n;
    bit       tx_idle_on   = 1'b0;
    bit       rx_stall_on  = 1'b0;
    bit       hold_req     = 1'b0;
    logic [INV_W-1:0] cur_inv = INV_RES_RST;
    longint   win_lo [3];
    longint   win_hi [3];

    always #5 aclk = ~aclk;

    ndt_voxel_count_and_neighbor_lookup_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_x              (s_x),
        .s_y              (s_y),
        .s_z              (s_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_index     (m_cell_index),
        .m_found          (m_found),
        .m_status         (m_status),
        .m_neighbor_count (m_neighbor_count),
        .m_last           (m_last)
    );

    ndtv_count_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_x              (s_x),
        .s_y              (s_y),
        .s_z              (s_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_index     (m_cell_index),
        .m_found          (m_found),
        .m_status         (m_status),
        .m_neighbor_count (m_neighbor_count),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("ndt_voxel_count_and_neighbor_lookup_core verification failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= aresetn;
                if (rx_stall_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 14);
                end
            end
        end
    end

    task automatic offer(input logic kind, input logic signed [COORD_W-1:0] x,
                         input logic signed [COORD_W-1:0] y,
                         input logic signed [COORD_W-1:0] z);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_x     <= x;
        s_y     <= y;
        s_z     <= z;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (32) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
    endtask

    task automatic set_grid(input int inv, input int lx, input int ly, input int lz,
                            input int sx, input int sy, input int sz, input int mp);
        int lo [3];
        int len [3];
        int a;
        lo[0]  = lx;
        lo[1]  = ly;
        lo[2]  = lz;
        len[0] = sx;
        len[1] = sy;
        len[2] = sz;
        cfg_put(REG_INV_RES, inv[15:0]);
        cfg_put(REG_MIN_X, lx[15:0]);
        cfg_put(REG_MIN_Y, ly[15:0]);
        cfg_put(REG_MIN_Z, lz[15:0]);
        cfg_put(REG_SIZE_X, sx[15:0]);
        cfg_put(REG_SIZE_Y, sy[15:0]);
        cfg_put(REG_SIZE_Z, sz[15:0]);
        cfg_put(REG_MIN_PTS, mp[15:0]);
        cfg_we  <= 1'b0;
        cur_inv = inv[15:0];
        for (a = 0; a < 3; a++) begin
            win_lo[a] = lo[a];
            win_hi[a] = lo[a] + ((len[a] > 0) ? len[a] - 1 : 0);
        end
    endtask

    // any point whose scaled coordinate floors to voxel v
    function automatic logic signed [COORD_W-1:0] coord_in_voxel(input longint v,
                                                                 input logic [INV_W-1:0] inv);
        longint a;
        longint c;
        longint span;
        longint x;
        longint inv_l;
        if (inv == 0) begin
            return COORD_W'($urandom);
        end
        inv_l = inv;
        a     = v * 65536;
        c     = (a >= 0) ? (a + inv_l - 1) / inv_l : -((-a) / inv_l);
        span  = 65536 / inv_l;
        x     = c + longint'($urandom_range(0, int'(span - 1)));
        if (x > 8388607) begin
            x = 8388607;
        end else if (x < -8388608) begin
            x = -8388608;
        end
        return x[COORD_W-1:0];
    endfunction

    task automatic random_item();
        logic signed [COORD_W-1:0] c [3];
        logic                      kind;
        longint                    v;
        int                        a;
        if ($urandom_range(0, 99) < 15) begin
            kind = 1'($urandom);
            for (a = 0; a < 3; a++) begin
                c[a] = COORD_W'($urandom);
            end
        end else begin
            kind = ($urandom_range(0, 99) < 60) ? KIND_ACC : KIND_QRY;
            for (a = 0; a < 3; a++) begin
                if ($urandom_range(0, 99) < 85) begin
                    v = win_lo[a] + longint'($urandom_range(0, int'(win_hi[a] - win_lo[a])));
                end else begin
                    v = win_lo[a] - 1
                        + longint'($urandom_range(0, int'(win_hi[a] - win_lo[a] + 2)));
                end
                c[a] = coord_in_voxel(v, cur_inv);
            end
        end
        offer(kind, c[0], c[1], c[2]);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: box edges, far outliers, negative fractions, empty and hit lookups
        offer(KIND_ACC, Q_MAX, Q_MIN, 24'sd0);
        offer(KIND_ACC, Q_MIN, Q_MAX, Q_MAX);
        offer(KIND_ACC, -24'sd1, -24'sd1, -24'sd1);
        offer(KIND_ACC, 24'sd896, 24'sd896, 24'sd896);
        offer(KIND_ACC, 24'sd1024, 24'sd0, 24'sd0);
        offer(KIND_ACC, -24'sd1024, -24'sd1024, -24'sd1024);
        offer(KIND_ACC, -24'sd1025, 24'sd0, 24'sd0);
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        repeat (6) offer(KIND_ACC, 24'sd0, 24'sd0, 24'sd0);
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        offer(KIND_QRY, -24'sd128, 24'sd0, 24'sd0);
        drain();

        // zero scale folds every point onto the origin voxel
        set_grid(0, -8, -8, -8, 16, 16, 16, 0);
        offer(KIND_QRY, Q_MAX, Q_MIN, 24'sd12345);
        offer(KIND_ACC, 24'sd4660, Q_MIN, Q_MAX);
        drain();

        // empty box
        set_grid(512, -8, -8, -8, 0, 16, 16, 6);
        offer(KIND_ACC, 24'sd0, 24'sd0, 24'sd0);
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        drain();

        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        set_grid(256, -2, -2, -2, 3, 3, 3, 2);
        for (n = 0; n < 90; n++) begin
            if (n == 40) begin
                hold_req = 1'b1;
            end
            random_item();
        end
        drain();

        set_grid(65535, -32768, 32767, 0, 3, 2, 5, 0);
        for (n = 0; n < 80; n++) begin
            if (n == 40) begin
                drain();
            end
            if (n == 55) begin
                tx_idle_on = 1'b0;
            end
            random_item();
        end
        drain();

        // box larger than the store: rows past the last cell count as outside
        tx_idle_on = 1'b1;
        set_grid(256, 0, 0, 0, 100, 100, 1, 1);
        win_lo[1] = 39;
        win_hi[1] = 41;
        for (n = 0; n < 70; n++) begin
            random_item();
        end
        drain();

        // bring one voxel up to the reporting threshold
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        set_grid(1, 0, 0, 0, 8191, 4096, 1, 30);
        for (n = 0; n < 29; n++) begin
            offer(KIND_ACC, coord_in_voxel(0, 16'd1), coord_in_voxel(0, 16'd1),
                  coord_in_voxel(0, 16'd1));
        end
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        offer(KIND_ACC, coord_in_voxel(0, 16'd1), coord_in_voxel(0, 16'd1),
              coord_in_voxel(0, 16'd1));
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        repeat (3) offer(KIND_ACC, 24'sd7, 24'sd9, 24'sd11);
        offer(KIND_QRY, 24'sd0, 24'sd0, 24'sd0);
        offer(KIND_QRY, -24'sd1, 24'sd0, 24'sd0);
        drain();

        set_grid($urandom_range(1, 2048), int'($urandom_range(0, 600)) - 300,
                 int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                 $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                 $urandom_range(0, 3));
        for (n = 0; n < 70; n++) begin
            random_item();
        end
        drain();
        repeat (64) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("ndt_voxel_count_and_neighbor_lookup_core verification clean");
        end else begin
            $display("ndt_voxel_count_and_neighbor_lookup_core verification failed");
        end
        $finish;
    end

endmodule
